### rtl/core/alert_packet_field_splitter_core_assert.svh
// Assertion macros shared by the alert packet field splitter RTL.
`ifndef ALERT_PACKET_FIELD_SPLITTER_CORE_ASSERT_SVH
`define ALERT_PACKET_FIELD_SPLITTER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define APFS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apfs: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define APFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apfs: next-cycle check failed");

`endif

### rtl/core/apfs_pkg.sv
// Package: types and constants of the alert packet field splitter.
`default_nettype none

package apfs_pkg;

  localparam int TitleMax = 32;
  localparam int BodyMax  = 128;

  localparam logic [5:0] TitleLimit = 6'(TitleMax - 1);
  localparam logic [7:0] BodyLimit  = 8'(BodyMax - 1);

  localparam logic [7:0] ChrNul   = 8'h00;
  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrSpace = 8'h20;

  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindTitle = 2'd1;
  localparam logic [1:0] KindBody  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } apfs_item_t;

  typedef struct packed {
    logic [1:0] char_kind;
    logic [7:0] char_value;
    logic [7:0] category;
    logic       packet_end;
    logic       packet_kept;
    logic       use_default_title;
  } apfs_result_t;

endpackage

`default_nettype wire

### rtl/core/apfs_if.sv
// Valid/ready channel interfaces: packet bytes in, split results out.
`default_nettype none

interface apfs_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface apfs_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] char_kind;
  logic [7:0] char_value;
  logic [7:0] category;
  logic       packet_end;
  logic       packet_kept;
  logic       use_default_title;
  modport source (output valid, char_kind, char_value, category, packet_end,
                  packet_kept, use_default_title, input ready);
  modport sink   (input valid, char_kind, char_value, category, packet_end,
                  packet_kept, use_default_title, output ready);
endinterface

`default_nettype wire

### rtl/core/alert_packet_field_splitter_core.sv
// Alert packet field splitter: top level.
//
// pkt carries the alert packet one byte per transaction, with last_byte set
// on the final byte. Byte 0 is the category, byte 1 is skipped, then title
// characters up to a NUL (a NUL as byte 2 is dropped) or the title limit,
// then body characters up to the body limit (CR/LF become space).
// res carries at most one transaction per byte: a title or body character,
// and/or the end-of-packet report (category, kept, default title needed).
// Bytes that emit nothing and are not final produce no transaction.
// An accepted byte is held in the input register, and its result in the result
// register until res takes it.
// Throughput: one byte per cycle while res does not stall; phase and counts update per byte.
// While res stalls, one result waits in the result register, bytes that emit
// nothing keep flowing, and the next emitting byte waits in the input register.
// Reset (rst, synchronous) empties both registers and returns the parser
// to expecting a category byte. After a final byte the parser returns there.
`default_nettype none

`include "alert_packet_field_splitter_core_assert.svh"

module alert_packet_field_splitter_core
  import apfs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  apfs_pkt_if.sink   pkt,
  apfs_res_if.source res
);

  logic         item_valid;
  apfs_item_t   item;
  logic         produce;
  apfs_result_t result;
  logic         can_load;
  logic         advance;
  logic         load;

  assign advance = item_valid && (!produce || can_load);
  assign load    = item_valid && produce && can_load;

  apfs_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .pkt        (pkt),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  apfs_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .item    (item),
    .produce (produce),
    .result  (result)
  );

  apfs_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .result   (result),
    .can_load (can_load),
    .res      (res)
  );

  `APFS_ASSERT_IMPLY(a_no_empty_result, res.valid && !res.packet_end, res.char_kind != KindNone)
  `APFS_ASSERT_IMPLY(a_report_only_at_end, res.valid && !res.packet_end,
                     res.category == 8'd0 && !res.packet_kept && !res.use_default_title)
  `APFS_ASSERT_IMPLY(a_default_needs_kept, res.valid && res.use_default_title, res.packet_kept)
  `APFS_ASSERT_NEXT(a_load_shows, load, res.valid)

endmodule

`default_nettype wire

### rtl/core/apfs_in_stage.sv
// Input register: holds one accepted byte until the parser consumes it.
`default_nettype none

module apfs_in_stage
  import apfs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  apfs_pkt_if.sink        pkt,
  input  wire logic       advance,
  output logic            item_valid,
  output apfs_item_t      item
);

  assign pkt.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (pkt.ready) begin
      item_valid <= pkt.valid;
    end
    if (pkt.valid && pkt.ready) begin
      item.data_byte <= pkt.data_byte;
      item.last_byte <= pkt.last_byte;
    end
  end

endmodule

`default_nettype wire

### rtl/core/apfs_parser.sv
// Packet phase tracker: classifies one byte per cycle while step is high, and updates counts.
`default_nettype none

module apfs_parser
  import apfs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire apfs_item_t item,
  output logic            produce,
  output apfs_result_t    result
);

  typedef enum logic [2:0] {
    PH_CATEGORY   = 3'd0,
    PH_SKIP_ONE   = 3'd1,
    PH_BYTE_TWO   = 3'd2,
    PH_TITLE      = 3'd3,
    PH_TITLE_FULL = 3'd4,
    PH_BODY       = 3'd5
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] held_category, held_category_next;
  logic [5:0] title_count, title_count_next;
  logic [7:0] body_count, body_count_next;
  logic [1:0] kind;
  logic [7:0] value;
  logic       is_nul;
  logic       kept;

  assign is_nul = (item.data_byte == ChrNul);

  always_comb begin
    phase_next         = phase;
    held_category_next = held_category;
    title_count_next   = title_count;
    body_count_next    = body_count;
    kind               = KindNone;
    value              = ChrNul;
    unique case (phase) inside
      PH_SKIP_ONE: begin
        phase_next = PH_BYTE_TWO;
      end
      PH_BYTE_TWO, PH_TITLE: begin
        if (is_nul) begin
          phase_next = (phase == PH_BYTE_TWO) ? PH_TITLE : PH_BODY;
        end else begin
          kind             = KindTitle;
          value            = item.data_byte;
          title_count_next = title_count + 6'd1;
          phase_next       = (title_count_next >= TitleLimit) ? PH_TITLE_FULL : PH_TITLE;
        end
      end
      PH_TITLE_FULL, PH_BODY: begin
        if (phase == PH_TITLE_FULL && is_nul) begin
          phase_next = PH_BODY;
        end else begin
          phase_next = PH_BODY;
          if (body_count < BodyLimit) begin
            kind            = KindBody;
            value           = (item.data_byte == ChrLf || item.data_byte == ChrCr) ?
                              ChrSpace : item.data_byte;
            body_count_next = body_count + 8'd1;
          end
        end
      end
      default: begin
        held_category_next = item.data_byte;
        phase_next         = PH_SKIP_ONE;
      end
    endcase
  end

  assign kept    = (title_count_next != '0) || (body_count_next != '0);
  assign produce = item.last_byte || (kind != KindNone);

  always_comb begin
    result.char_kind         = kind;
    result.char_value        = value;
    result.packet_end        = item.last_byte;
    result.category          = item.last_byte ? held_category_next : 8'd0;
    result.packet_kept       = item.last_byte && kept;
    result.use_default_title = item.last_byte && kept && (title_count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_CATEGORY;
      held_category <= '0;
      title_count   <= '0;
      body_count    <= '0;
    end else if (step) begin
      if (item.last_byte) begin
        phase         <= PH_CATEGORY;
        held_category <= '0;
        title_count   <= '0;
        body_count    <= '0;
      end else begin
        phase         <= phase_next;
        held_category <= held_category_next;
        title_count   <= title_count_next;
        body_count    <= body_count_next;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/apfs_out_stage.sv
// Result register: holds one result transaction until the receiver takes it.
`default_nettype none

module apfs_out_stage
  import apfs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire apfs_result_t result,
  output logic              can_load,
  apfs_res_if.source        res
);

  apfs_result_t held;

  assign can_load = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (load) begin
      held <= result;
    end
  end

  assign res.char_kind         = held.char_kind;
  assign res.char_value        = held.char_value;
  assign res.category          = held.category;
  assign res.packet_end        = held.packet_end;
  assign res.packet_kept       = held.packet_kept;
  assign res.use_default_title = held.use_default_title;

endmodule

`default_nettype wire
